// File: hdl/nldm_pkg.sv
// ----------------------------------------------------------------------------
// nldm_pkg
// Shared codes and default sizes for the leaf distance matrix block.
// ----------------------------------------------------------------------------
package nldm_pkg;

  localparam int unsigned DEF_MAX_TAXA   = 256;
  localparam int unsigned DEF_DEPTH_BITS = 16;
  localparam int unsigned DEF_ACC_BITS   = 32;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned OUT_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN  = 3'd0,
    MODE_CLOSE = 3'd1,
    MODE_COLON = 3'd2,
    MODE_COMMA = 3'd3,
    MODE_LEAF  = 3'd4,
    MODE_END   = 3'd5,
    MODE_READ  = 3'd6
  } mode_t;

  // Previous token kind at start of tree
  localparam logic [MODE_W-1:0] KIND_NONE = 3'd7;

endpackage

// File: hdl/nldm_tok_if.sv
// ----------------------------------------------------------------------------
// nldm_tok_if
// Token request channel: valid/ready with mode, taxon and read column.
// ----------------------------------------------------------------------------
interface nldm_tok_if
  import nldm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   taxon_id;
  logic [ID_W-1:0]   read_col;

  modport source (output valid, mode, taxon_id, read_col, input ready);
  modport sink   (input valid, mode, taxon_id, read_col, output ready);
endinterface

// File: hdl/nldm_res_if.sv
// ----------------------------------------------------------------------------
// nldm_res_if
// Result channel: valid/ready with matrix entry values and sticky flag.
// ----------------------------------------------------------------------------
interface nldm_res_if
  import nldm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] dist_sum;
  logic [OUT_W-1:0] pair_count;
  logic             overflow;

  modport source (output valid, dist_sum, pair_count, overflow, input ready);
  modport sink   (input valid, dist_sum, pair_count, overflow, output ready);
endinterface

// File: hdl/nldm_ram.sv
// ----------------------------------------------------------------------------
// nldm_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module nldm_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 256,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/newick_leaf_distance_matrix.sv
// ----------------------------------------------------------------------------
// newick_leaf_distance_matrix
// Accumulates leaf-to-leaf topological distances over a stream of tree tokens.
// ----------------------------------------------------------------------------
// Latency/throughput: one request at a time, none while a result waits unaccepted.
//   Open and close walk the seen list, updating each leaf's counts; a leaf walks
//   it, updating both matrix entries per seen leaf, then appends itself; end of
//   tree walks it, clearing the counts; a read registers its result in RD.
// Reset: synchronous rst starts a clearing pass over all MAX_TAXA*MAX_TAXA
//   entries of the matrix RAM (and the count RAM); no request is taken until done.
module newick_leaf_distance_matrix
  import nldm_pkg::*;
#(
  parameter int unsigned MAX_TAXA   = DEF_MAX_TAXA,
  parameter int unsigned DEPTH_BITS = DEF_DEPTH_BITS,
  parameter int unsigned ACC_BITS   = DEF_ACC_BITS
) (
  input  logic clk,
  input  logic rst,
  nldm_tok_if.sink   tok,
  nldm_res_if.source res
);
  localparam int unsigned TW = $clog2(MAX_TAXA);
  localparam int unsigned CW = $clog2(MAX_TAXA + 1);
  localparam int unsigned MD = MAX_TAXA * MAX_TAXA;
  localparam int unsigned MW = $clog2(MD);
  localparam int unsigned DB = DEPTH_BITS;
  localparam int unsigned AB = ACC_BITS;
  localparam int unsigned SW = ((AB > DB + 1) ? AB : DB + 1) + 1;

  typedef enum logic [3:0] {
    CLR, IDLE, RD,
    W0, W1, W2,
    L0, L1, L2, L3, L4, APP,
    E0, E1
  } state_t;

  state_t state;

  // Per-request registers
  logic [CW-1:0]     k;
  logic [CW-1:0]     seen_count;
  logic [MODE_W-1:0] prev_kind;
  logic              ovf;
  logic              tok_open;
  logic [TW-1:0]     tok_id;
  logic [TW-1:0]     other;
  logic [DB:0]       step;
  logic [MW-1:0]     addr_a;
  logic [MW-1:0]     addr_b;
  logic [MW-1:0]     clr_addr;

  logic             res_valid;
  logic [OUT_W-1:0] res_dist;
  logic [OUT_W-1:0] res_pair;
  logic             res_ovf;
  logic             rd_hit;

  // RAM ports
  logic          s_we;
  logic [TW-1:0] s_waddr, s_wdata, s_raddr, s_rdata;
  logic            c_we;
  logic [TW-1:0]   c_waddr, c_raddr;
  logic [2*DB-1:0] c_wdata, c_rdata;
  logic            m_we;
  logic [MW-1:0]   m_waddr, m_raddr;
  logic [2*AB-1:0] m_wdata, m_rdata;

  nldm_ram #(.W(TW), .D(MAX_TAXA)) u_seen (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  nldm_ram #(.W(2*DB), .D(MAX_TAXA)) u_cnt (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );
  nldm_ram #(.W(2*AB), .D(MD)) u_mat (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  // Request decode
  logic          accept;
  logic          id_ok, col_ok;
  logic [TW-1:0] in_row, in_col;

  assign tok.ready = (state == IDLE) && (!res_valid || res.ready);
  assign accept    = tok.valid && tok.ready;
  assign id_ok     = 32'(tok.taxon_id) < MAX_TAXA;
  assign col_ok    = 32'(tok.read_col) < MAX_TAXA;
  assign in_row    = TW'(tok.taxon_id);
  assign in_col    = TW'(tok.read_col);

  // Count update for open/close walk
  logic [DB-1:0]   up_old, op_old, up_new, op_new;
  logic [2*DB-1:0] cnt_next;
  logic            cnt_ovf;
  localparam logic [DB-1:0] DMAX = {DB{1'b1}};

  always_comb begin
    op_old  = c_rdata[2*DB-1:DB];
    up_old  = c_rdata[DB-1:0];
    op_new  = op_old;
    up_new  = up_old;
    cnt_ovf = 1'b0;
    if (tok_open) begin
      if (op_old == DMAX) cnt_ovf = 1'b1; else op_new = op_old + 1'b1;
      if (up_old == DMAX) cnt_ovf = 1'b1; else up_new = up_old + 1'b1;
    end else if (op_old != '0) begin
      op_new = op_old - 1'b1;
      if (up_old != '0) up_new = up_old - 1'b1;
    end else begin
      if (up_old == DMAX) cnt_ovf = 1'b1; else up_new = up_old + 1'b1;
    end
    cnt_next = {op_new, up_new};
  end

  // Saturating matrix update: dist += step, pair += 1
  logic [DB:0]     step_now;
  logic [DB:0]     step_use;
  logic [SW-1:0]   dsum;
  logic [AB-1:0]   dist_old, pair_old, dist_new, pair_new;
  logic [2*AB-1:0] mat_next;
  logic            mat_ovf;
  localparam logic [AB-1:0] AMAX = {AB{1'b1}};

  always_comb begin
    step_now = {1'b0, c_rdata[DB-1:0]} + (DB+1)'(2);
    step_use = (state == L2) ? step_now : step;
    dist_old = m_rdata[AB-1:0];
    pair_old = m_rdata[2*AB-1:AB];
    dsum     = SW'(dist_old) + SW'(step_use);
    mat_ovf  = 1'b0;
    if (dsum > SW'(AMAX)) begin
      dist_new = AMAX;
      mat_ovf  = 1'b1;
    end else begin
      dist_new = AB'(dsum);
    end
    if (pair_old == AMAX) begin
      pair_new = AMAX;
      mat_ovf  = 1'b1;
    end else begin
      pair_new = pair_old + 1'b1;
    end
    mat_next = {pair_new, dist_new};
  end

  // RAM port steering
  always_comb begin
    s_we    = 1'b0;
    s_waddr = seen_count[TW-1:0];
    s_wdata = tok_id;
    s_raddr = k[TW-1:0];
    c_we    = 1'b0;
    c_waddr = other;
    c_wdata = cnt_next;
    c_raddr = s_rdata;
    m_we    = 1'b0;
    m_waddr = addr_a;
    m_wdata = mat_next;
    m_raddr = addr_b;
    unique case (state)
      CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_addr;
        m_wdata = '0;
        c_we    = 32'(clr_addr) < MAX_TAXA;
        c_waddr = TW'(clr_addr);
        c_wdata = '0;
      end
      IDLE: begin
        // issue the read of a read request at accept time
        m_raddr = MW'(in_row) * MW'(MAX_TAXA) + MW'(in_col);
      end
      L1: begin
        m_raddr = MW'(s_rdata) * MW'(MAX_TAXA) + MW'(tok_id);
      end
      W2: begin
        c_we = 1'b1;
      end
      L2: begin
        m_we = 1'b1;
      end
      L4: begin
        m_we    = 1'b1;
        m_waddr = addr_b;
      end
      APP: begin
        s_we = seen_count < CW'(MAX_TAXA);
      end
      E1: begin
        c_we    = 1'b1;
        c_waddr = s_rdata;
        c_wdata = '0;
      end
      default: ;
    endcase
  end

  logic last_k;
  assign last_k = (k + 1'b1) == seen_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLR;
      clr_addr   <= '0;
      k          <= '0;
      seen_count <= '0;
      prev_kind  <= KIND_NONE;
      ovf        <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res.ready) res_valid <= 1'b0;
      unique case (state)
        CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MW'(MD - 1)) state <= IDLE;
        end
        IDLE: begin
          k <= '0;
          if (accept) begin
            tok_id   <= in_row;
            tok_open <= tok.mode == MODE_OPEN;
            rd_hit   <= id_ok && col_ok;
            case (tok.mode)
              MODE_OPEN, MODE_CLOSE: begin
                prev_kind <= tok.mode;
                if (seen_count != '0) state <= W0;
              end
              MODE_COLON, MODE_COMMA: prev_kind <= tok.mode;
              MODE_LEAF: begin
                // drop labels and branch lengths after a close or colon
                if (prev_kind != MODE_CLOSE && prev_kind != MODE_COLON) begin
                  prev_kind <= tok.mode;
                  if (!id_ok) ovf <= 1'b1;
                  else if (seen_count != '0) state <= L0;
                  else state <= APP;
                end
              end
              MODE_END: begin
                prev_kind <= KIND_NONE;
                if (seen_count != '0) state <= E0;
              end
              MODE_READ: state <= RD;
              default: ;
            endcase
          end
        end
        RD: begin
          res_valid <= 1'b1;
          res_dist  <= rd_hit ? OUT_W'(m_rdata[AB-1:0]) : '0;
          res_pair  <= rd_hit ? OUT_W'(m_rdata[2*AB-1:AB]) : '0;
          res_ovf   <= ovf;
          state     <= IDLE;
        end
        W0: state <= W1;
        W1: begin
          other <= s_rdata;
          state <= W2;
        end
        W2: begin
          if (cnt_ovf) ovf <= 1'b1;
          k     <= k + 1'b1;
          state <= last_k ? IDLE : W0;
        end
        L0: state <= L1;
        L1: begin
          addr_a <= MW'(s_rdata) * MW'(MAX_TAXA) + MW'(tok_id);
          addr_b <= MW'(tok_id) * MW'(MAX_TAXA) + MW'(s_rdata);
          state  <= L2;
        end
        L2: begin
          step  <= step_now;
          if (mat_ovf) ovf <= 1'b1;
          state <= L3;
        end
        L3: state <= L4;
        L4: begin
          if (mat_ovf) ovf <= 1'b1;
          k     <= k + 1'b1;
          state <= last_k ? APP : L0;
        end
        APP: begin
          if (seen_count < CW'(MAX_TAXA)) seen_count <= seen_count + 1'b1;
          else ovf <= 1'b1;
          state <= IDLE;
        end
        E0: state <= E1;
        E1: begin
          k <= k + 1'b1;
          if (last_k) begin
            seen_count <= '0;
            state      <= IDLE;
          end else begin
            state <= E0;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign res.valid      = res_valid;
  assign res.dist_sum   = res_dist;
  assign res.pair_count = res_pair;
  assign res.overflow   = res_ovf;

  // Checks
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen_count <= CW'(MAX_TAXA)) else $error("seen count beyond list depth");

  a_no_req_in_clear: assert property (@(posedge clk)
    (state == CLR) |-> !tok.ready) else $error("request taken during clearing pass");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf) else $error("overflow flag dropped");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    (state == W2 || state == L4 || state == E1) |-> (k < seen_count))
    else $error("walk index past seen count");
endmodule

// File: tb/newick_leaf_distance_matrix_tb.sv
// ----------------------------------------------------------------------------
// newick_leaf_distance_matrix_tb
// Feeds token streams for small random trees into the distance matrix block.
// A cycle-free predictor models the per-tree counts and both matrices, and
// each read result is checked against it. Directed trees cover the extremes,
// repeated taxa, labels and a full seen list.
// ----------------------------------------------------------------------------
module newick_leaf_distance_matrix_tb;
  import nldm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NTAXA = DEF_MAX_TAXA;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int unsigned LIMIT = 4_000_000;
  localparam int unsigned TAIL_CYCLES = 1500;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   taxon;
    logic [ID_W-1:0]   col;
    bit                drain;  // wait for all reads to return before offering
  } tok_req_t;

  typedef struct {
    logic [OUT_W-1:0] dsum;
    logic [OUT_W-1:0] pairs;
    logic             ovf;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nldm_tok_if tok_ch ();
  nldm_res_if res_ch ();

  newick_leaf_distance_matrix u_top (
    .clk (clk),
    .rst (rst),
    .tok (tok_ch),
    .res (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow state of the block
  // --------------------------------------------------------------------------
  logic [DEF_DEPTH_BITS-1:0] up_cnt  [NTAXA];
  logic [DEF_DEPTH_BITS-1:0] open_cnt[NTAXA];
  logic [ID_W-1:0]           seen    [NTAXA];
  int unsigned               seen_n;
  logic [MODE_W-1:0]         last_kind;
  logic [OUT_W-1:0]          dist_acc[NTAXA*NTAXA];
  logic [OUT_W-1:0]          pair_mat[NTAXA*NTAXA];
  logic                      ovf_flag;

  tok_req_t req_q[$];
  entry_t   entry_q[$];

  int unsigned errors = 0;
  int unsigned reads_checked = 0;
  int unsigned trees_sent = 0;
  int unsigned leaves_sent = 0;
  int unsigned cycles = 0;

  function automatic logic [DEF_DEPTH_BITS-1:0] bump_depth(logic [DEF_DEPTH_BITS-1:0] v);
    if (&v) begin
      ovf_flag = 1'b1;
      return v;
    end
    return v + 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] acc_add(logic [OUT_W-1:0] a, logic [OUT_W:0] step);
    logic [OUT_W+1:0] sum;
    sum = {2'b00, a} + {1'b0, step};
    if (sum > {2'b00, {OUT_W{1'b1}}}) begin
      ovf_flag = 1'b1;
      return {OUT_W{1'b1}};
    end
    return sum[OUT_W-1:0];
  endfunction

  function automatic void clear_tree_state();
    for (int i = 0; i < NTAXA; i++) begin
      up_cnt[i] = '0;
      open_cnt[i] = '0;
    end
    seen_n = 0;
    last_kind = KIND_NONE;
  endfunction

  // Advance the shadow state by one accepted request; queue a result for reads.
  function automatic void apply_token(tok_req_t r);
    int unsigned s;
    int unsigned a;
    int unsigned b;
    entry_t e;
    case (r.mode)
      MODE_OPEN: begin
        for (int k = 0; k < seen_n; k++) begin
          s = seen[k];
          open_cnt[s] = bump_depth(open_cnt[s]);
          up_cnt[s] = bump_depth(up_cnt[s]);
        end
        last_kind = r.mode;
      end
      MODE_CLOSE: begin
        for (int k = 0; k < seen_n; k++) begin
          s = seen[k];
          if (open_cnt[s] != 0) begin
            open_cnt[s]--;
            if (up_cnt[s] != 0) up_cnt[s]--;
          end else begin
            up_cnt[s] = bump_depth(up_cnt[s]);
          end
        end
        last_kind = r.mode;
      end
      MODE_COLON, MODE_COMMA: begin
        last_kind = r.mode;
      end
      MODE_LEAF: begin
        // drop labels and branch lengths that follow a close or a colon
        if (last_kind != MODE_CLOSE && last_kind != MODE_COLON) begin
          for (int k = 0; k < seen_n; k++) begin
            s = seen[k];
            a = s * NTAXA + r.taxon;
            b = r.taxon * NTAXA + s;
            dist_acc[a] = acc_add(dist_acc[a], {1'b0, 16'd0, up_cnt[s]} + (OUT_W+1)'(2));
            dist_acc[b] = acc_add(dist_acc[b], {1'b0, 16'd0, up_cnt[s]} + (OUT_W+1)'(2));
            pair_mat[a] = acc_add(pair_mat[a], (OUT_W+1)'(1));
            pair_mat[b] = acc_add(pair_mat[b], (OUT_W+1)'(1));
          end
          if (seen_n < NTAXA) begin
            seen[seen_n] = r.taxon;
            seen_n++;
          end else begin
            ovf_flag = 1'b1;
          end
          last_kind = r.mode;
        end
      end
      MODE_END: clear_tree_state();
      MODE_READ: begin
        a = r.taxon * NTAXA + r.col;
        e.dsum = dist_acc[a];
        e.pairs = pair_mat[a];
        e.ovf = ovf_flag;
        entry_q.insert(entry_q.size(), e);
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  logic [ID_W-1:0] hot_ids[8];

  function automatic void push_tok(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
                                   logic [ID_W-1:0] c = '0, bit drain = 1'b0);
    tok_req_t r;
    r.mode = m;
    r.taxon = id;
    r.col = c;
    r.drain = drain;
    req_q.insert(req_q.size(), r);
    if (m == MODE_LEAF) leaves_sent++;
    if (m == MODE_END) trees_sent++;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(0, 3) != 0) ? hot_ids[3'($urandom_range(0, 7))]
                                       : ID_W'($urandom_range(0, 255));
  endfunction

  // Emit one subtree, with optional internal label and branch length.
  function automatic void emit_clade(int lvl);
    int n;
    if (lvl == 0 || $urandom_range(0, 2) == 0) begin
      push_tok(MODE_LEAF, pick_id());
    end else begin
      n = $urandom_range(2, 3);
      push_tok(MODE_OPEN, '0);
      for (int i = 0; i < n; i++) begin
        if (i != 0) push_tok(MODE_COMMA, '0);
        emit_clade(lvl - 1);
      end
      push_tok(MODE_CLOSE, '0);
      if ($urandom_range(0, 3) == 0) push_tok(MODE_LEAF, ID_W'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      push_tok(MODE_COLON, '0);
      push_tok(MODE_LEAF, ID_W'($urandom));
    end
  endfunction

  function automatic void emit_noise();
    push_tok(MODE_W'($urandom_range(0, 7)), ID_W'($urandom), ID_W'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps
  // --------------------------------------------------------------------------
  tok_req_t cur;
  bit have_req = 1'b0;
  bit took = 1'b0;
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;

  // Predict on the accepting edge so the expected queue stays in order.
  always @(posedge clk) begin
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      apply_token(cur);
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (took) begin
      took = 1'b0;
      have_req = 1'b0;
    end
    if (!rst && !have_req) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0 && !(req_q[0].drain && entry_q.size() != 0)) begin
        cur = req_q.pop_front();
        have_req = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
        end
      end
    end
    tok_ch.valid <= have_req;
    tok_ch.mode <= cur.mode;
    tok_ch.taxon_id <= cur.taxon;
    tok_ch.read_col <= cur.col;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern that shifts through three modes, one long hold-off
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit held_once = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (!held_once && reads_checked == 40) begin
      // hold off long enough that the block backs up onto its input
      held_once = 1'b1;
      hold_left = 800;
      res_ch.ready <= 1'b0;
    end else begin
      case ((cycles >> 9) % 3)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 1) == 0);
        default: res_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    entry_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (entry_q.size() == 0) begin
        $display("%0t: unexpected result dist=%0d pairs=%0d ovf=%0b", $time,
                 res_ch.dist_sum, res_ch.pair_count, res_ch.overflow);
        errors++;
      end else begin
        e = entry_q.pop_front();
        reads_checked++;
        if (res_ch.dist_sum !== e.dsum) begin
          $display("%0t: dist_sum expected %0d actual %0d", $time, e.dsum, res_ch.dist_sum);
          errors++;
        end
        if (res_ch.pair_count !== e.pairs) begin
          $display("%0t: pair_count expected %0d actual %0d", $time, e.pairs,
                   res_ch.pair_count);
          errors++;
        end
        if (res_ch.overflow !== e.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, res_ch.overflow);
          errors++;
        end
      end
    end
  end

  // Run limit, generous over reset clearing pass and the seen-list fill
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("newick_leaf_distance_matrix_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned results_goal;
    for (int i = 0; i < NTAXA * NTAXA; i++) begin
      dist_acc[i] = '0;
      pair_mat[i] = '0;
    end
    for (int i = 0; i < NTAXA; i++) seen[i] = '0;
    clear_tree_state();
    ovf_flag = 1'b0;
    for (int i = 0; i < 8; i++) hot_ids[i] = ID_W'($urandom);

    // Directed: corners, every token kind, repeats, labels, unused mode
    push_tok(MODE_READ, 8'd0, 8'd0);
    push_tok(MODE_READ, 8'd255, 8'd255);
    push_tok(MODE_OPEN, '0);
    push_tok(MODE_LEAF, 8'd255);
    push_tok(MODE_COMMA, '0);
    push_tok(MODE_LEAF, 8'd0);
    push_tok(MODE_CLOSE, '0);
    push_tok(MODE_LEAF, 8'd77);   // internal label, dropped
    push_tok(MODE_COLON, '0);
    push_tok(MODE_LEAF, 8'd3);    // branch length, dropped
    push_tok(MODE_UNUSED, 8'hAA, 8'h55);
    push_tok(MODE_LEAF, 8'd5);
    push_tok(MODE_LEAF, 8'd5);    // repeated taxon, still after the colon, dropped
    push_tok(MODE_END, '0);
    push_tok(MODE_READ, 8'd255, 8'd0);
    push_tok(MODE_READ, 8'd0, 8'd255);
    push_tok(MODE_READ, 8'd5, 8'd5);
    push_tok(MODE_READ, 8'd5, 8'd255, 1'b1);

    // Random: mostly well-formed trees, some noise, reads between trees
    while (req_q.size() < 1700) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) emit_noise();
      end else begin
        emit_clade($urandom_range(1, 3));
      end
      if ($urandom_range(0, 7) != 0) push_tok(MODE_END, '0);
      repeat ($urandom_range(1, 3)) push_tok(MODE_READ, pick_id(), pick_id());
      if ($urandom_range(0, 3) == 0) push_tok(MODE_READ, ID_W'($urandom), ID_W'($urandom));
    end
    push_tok(MODE_END, '0);
    push_tok(MODE_READ, hot_ids[0], hot_ids[1], 1'b1);

    // Fill the seen list past its end
    for (int i = 0; i < NTAXA + 2; i++) push_tok(MODE_LEAF, ID_W'(i));
    push_tok(MODE_READ, 8'd0, 8'd0);
    push_tok(MODE_READ, 8'd1, 8'd255);
    push_tok(MODE_END, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (req_q.size() == 0 && !have_req && entry_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d trees, %0d leaf tokens, %0d checked reads in %0d cycles.",
             trees_sent, leaves_sent, reads_checked, cycles);
    if (errors == 0) begin
      $display("newick_leaf_distance_matrix_tb: clean");
    end else begin
      $display("newick_leaf_distance_matrix_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/nldm_pkg.sv
hdl/nldm_tok_if.sv
hdl/nldm_res_if.sv
hdl/nldm_ram.sv
hdl/newick_leaf_distance_matrix.sv
tb/newick_leaf_distance_matrix_tb.sv
